[hdl/lrl_pkg.sv]
// Shared types and constants for the link recovery ladder.
// Used by lrl_cfg, lrl_core and link_recovery_ladder; no dependencies.
package lrl_pkg;

	// Default widths of the internal counters and time values
	localparam int COUNTER_WIDTH_DEF = 32;
	localparam int TIME_WIDTH_DEF    = 32;

	// Field widths of the stream payloads
	localparam int CNT_OUT_W  = 32;
	localparam int TIME_IN_W  = 32;
	localparam int STREAK_W   = 16;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 32;
	localparam int S_TDATA_W  = 40;
	localparam int M_TDATA_W  = 184;

	localparam logic [STREAK_W-1:0]   STREAK_MAX       = 16'hFFFF;
	localparam logic [STREAK_W-1:0]   THRESHOLD_RESET  = 16'd3;
	localparam logic [CFG_DATA_W-1:0] BACKOFF_BASE_RST = 32'd1000;
	localparam logic [CFG_DATA_W-1:0] BACKOFF_MAX_RST  = 32'd60000;

	typedef enum logic [1:0] {
		MODE_NORMAL  = 2'd0,
		MODE_RECOVER = 2'd1,
		MODE_BACKOFF = 2'd2
	} mode_t;

	typedef enum logic [1:0] {
		ACT_ATTEMPT   = 2'd0,
		ACT_BUSCLEAR  = 2'd1,
		ACT_HARDRESET = 2'd2,
		ACT_WAIT      = 2'd3
	} act_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_FAIL_THRESHOLD = 2'd0,
		REG_BACKOFF_BASE   = 2'd1,
		REG_BACKOFF_MAX    = 2'd2
	} reg_idx_t;

	typedef struct packed {
		logic [STREAK_W-1:0]   fail_threshold;
		logic [CFG_DATA_W-1:0] backoff_base_ms;
		logic [CFG_DATA_W-1:0] backoff_max_ms;
	} cfg_t;

	typedef struct packed {
		logic                 func;
		act_t                 step_done;
		logic                 ok;
		logic [TIME_IN_W-1:0] now_ms;
	} item_t;

	typedef struct packed {
		act_t                 next_step;
		logic                 degraded;
		logic [CNT_OUT_W-1:0] failure_count;
		logic [CNT_OUT_W-1:0] recovery_count;
		logic [CNT_OUT_W-1:0] bus_clear_count;
		logic [CNT_OUT_W-1:0] hard_reset_count;
		logic [STREAK_W-1:0]  streak_count;
		logic [CNT_OUT_W-1:0] last_recovery_time;
	} result_t;

endpackage

[hdl/lrl_cfg.sv]
// Configuration register file for the link recovery ladder.
// Depends on lrl_pkg for the register indexes and the cfg_t bundle.
module lrl_cfg
	import lrl_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	output cfg_t                  cfg
);

	cfg_t cfg_q;

	// Decode the index and load the addressed register; drop unknown indexes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.fail_threshold  <= THRESHOLD_RESET;
			cfg_q.backoff_base_ms <= BACKOFF_BASE_RST;
			cfg_q.backoff_max_ms  <= BACKOFF_MAX_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_FAIL_THRESHOLD: cfg_q.fail_threshold  <= cfg_data[STREAK_W-1:0];
				REG_BACKOFF_BASE:   cfg_q.backoff_base_ms <= cfg_data;
				REG_BACKOFF_MAX:    cfg_q.backoff_max_ms  <= cfg_data;
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

[hdl/lrl_core.sv]
// Ladder state, counters and the per-item update and plan logic.
// Depends on lrl_pkg; state advances only when upd is high.
module lrl_core
	import lrl_pkg::*;
#(
	parameter int COUNTER_WIDTH = COUNTER_WIDTH_DEF,
	parameter int TIME_WIDTH    = TIME_WIDTH_DEF
) (
	input  logic    clk,
	input  logic    arst_n,
	input  cfg_t    cfg,
	input  item_t   item,
	input  logic    upd,
	output result_t res
);

	localparam int CW = COUNTER_WIDTH;
	localparam int TW = TIME_WIDTH;

	mode_t               mode_q, n_mode;
	logic                rung_q, n_rung;
	logic [STREAK_W-1:0] streak_q, n_streak;
	logic [31:0]         len_q, n_len;
	logic [TW-1:0]       deadline_q, n_deadline;
	logic [CW-1:0]       fail_q, n_fail;
	logic [CW-1:0]       recov_q, n_recov;
	logic [CW-1:0]       bus_q, n_bus;
	logic [CW-1:0]       hard_q, n_hard;
	logic [TW-1:0]       last_q, n_last;

	logic [TW-1:0] now_tw;
	logic          recovered;
	logic          go_backoff;
	logic [32:0]   len_dbl;
	logic [63:0]   deadline_sum;
	logic [TW-1:0] diff;
	logic [63:0]   fail_x, recov_x, bus_x, hard_x, last_x;

	assign now_tw = TW'(item.now_ms);

	// Next state: apply one report, queries leave everything as is
	always_comb begin
		n_mode     = mode_q;
		n_rung     = rung_q;
		n_streak   = streak_q;
		n_len      = len_q;
		n_deadline = deadline_q;
		n_fail     = fail_q;
		n_recov    = recov_q;
		n_bus      = bus_q;
		n_hard     = hard_q;
		n_last     = last_q;
		recovered  = 1'b0;
		go_backoff = 1'b0;
		len_dbl    = {len_q, 1'b0};
		deadline_sum = '0;
		if (item.func) begin
			case (item.step_done)
				ACT_ATTEMPT: begin
					if (item.ok) begin
						if (mode_q != MODE_NORMAL) begin
							recovered = 1'b1;
						end else begin
							n_streak = '0;
						end
					end else begin
						n_fail = fail_q + CW'(1);
						if (streak_q != STREAK_MAX) begin
							n_streak = streak_q + STREAK_W'(1);
						end
						if (mode_q == MODE_BACKOFF) begin
							n_mode = MODE_RECOVER;
							n_rung = 1'b0;
						end else if (mode_q == MODE_NORMAL &&
						             n_streak >= cfg.fail_threshold) begin
							n_mode = MODE_RECOVER;
							n_rung = 1'b0;
						end
					end
				end
				ACT_BUSCLEAR: begin
					n_bus = bus_q + CW'(1);
					if (item.ok) begin
						recovered = 1'b1;
					end else begin
						n_rung = 1'b1;
					end
				end
				ACT_HARDRESET: begin
					n_hard = hard_q + CW'(1);
					if (item.ok) begin
						recovered = 1'b1;
					end else begin
						go_backoff = 1'b1;
					end
				end
				default: ;
			endcase
		end

		// Full ladder miss: restart at base or double and cap
		if (go_backoff) begin
			if (len_q == '0) begin
				n_len = cfg.backoff_base_ms;
			end else if (len_q < cfg.backoff_max_ms) begin
				n_len = (len_dbl > {1'b0, cfg.backoff_max_ms}) ? cfg.backoff_max_ms
				                                                : len_dbl[31:0];
			end
			deadline_sum = 64'(now_tw) + 64'(n_len);
			n_deadline   = TW'(deadline_sum);
			n_mode       = MODE_BACKOFF;
			n_rung       = 1'b0;
		end

		// Back to normal on any recovery
		if (recovered) begin
			n_recov  = recov_q + CW'(1);
			n_last   = now_tw;
			n_mode   = MODE_NORMAL;
			n_rung   = 1'b0;
			n_streak = '0;
			n_len    = '0;
		end
	end

	// Result: plan for the updated state at the same time stamp
	always_comb begin
		diff    = now_tw - n_deadline;
		fail_x  = 64'(n_fail);
		recov_x = 64'(n_recov);
		bus_x   = 64'(n_bus);
		hard_x  = 64'(n_hard);
		last_x  = 64'(n_last);
		case (n_mode)
			MODE_RECOVER: res.next_step = n_rung ? ACT_HARDRESET : ACT_BUSCLEAR;
			MODE_BACKOFF: res.next_step = diff[TW-1] ? ACT_WAIT : ACT_ATTEMPT;
			default:      res.next_step = ACT_ATTEMPT;
		endcase
		res.degraded           = (n_mode != MODE_NORMAL);
		res.failure_count      = fail_x[CNT_OUT_W-1:0];
		res.recovery_count     = recov_x[CNT_OUT_W-1:0];
		res.bus_clear_count    = bus_x[CNT_OUT_W-1:0];
		res.hard_reset_count   = hard_x[CNT_OUT_W-1:0];
		res.streak_count       = n_streak;
		res.last_recovery_time = last_x[CNT_OUT_W-1:0];
	end

	// Commit the update when the item leaves the input stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q     <= MODE_NORMAL;
			rung_q     <= 1'b0;
			streak_q   <= '0;
			len_q      <= '0;
			deadline_q <= '0;
			fail_q     <= '0;
			recov_q    <= '0;
			bus_q      <= '0;
			hard_q     <= '0;
			last_q     <= '0;
		end else if (upd) begin
			mode_q     <= n_mode;
			rung_q     <= n_rung;
			streak_q   <= n_streak;
			len_q      <= n_len;
			deadline_q <= n_deadline;
			fail_q     <= n_fail;
			recov_q    <= n_recov;
			bus_q      <= n_bus;
			hard_q     <= n_hard;
			last_q     <= n_last;
		end
	end

	// State only moves with an item
	a_hold_idle: assert property (@(posedge clk) disable iff (!arst_n)
		!upd |=> $stable(mode_q) && $stable(fail_q) && $stable(streak_q))
		else $error("ladder state moved without an item");

	// A reported wait changes nothing
	a_wait_noop: assert property (@(posedge clk) disable iff (!arst_n)
		upd && item.func && item.step_done == ACT_WAIT
		|=> $stable(mode_q) && $stable(fail_q) && $stable(bus_q) && $stable(hard_q))
		else $error("wait report changed state");

	// A failed attempt bumps the failure total by one
	a_fail_inc: assert property (@(posedge clk) disable iff (!arst_n)
		upd && item.func && item.step_done == ACT_ATTEMPT && !item.ok
		|=> fail_q == $past(fail_q) + CW'(1))
		else $error("failure total not advanced");

	// A successful bus clear always lands in normal mode with an empty streak
	a_clear_ok: assert property (@(posedge clk) disable iff (!arst_n)
		upd && item.func && item.step_done == ACT_BUSCLEAR && item.ok
		|=> mode_q == MODE_NORMAL && streak_q == '0 && len_q == '0)
		else $error("recovery did not restore normal mode");

endmodule

[hdl/link_recovery_ladder.sv]
// An input beat passes the input stage, then the result stage, to become its result beat.
// Throughput: one item per cycle while m_tready is high; a result waiting on m_tready
// holds a full input stage, which takes no new beat until the result register drains.
// The plan, counter update and backoff doubling are one pass of logic on state registers.
// Reset (arst_n low): mode normal, all counters and timers zero, registers at their
// defaults (threshold 3, base 1000 ms, max 60000 ms), both stages empty.
module link_recovery_ladder
	import lrl_pkg::*;
#(
	parameter int COUNTER_WIDTH = COUNTER_WIDTH_DEF,
	parameter int TIME_WIDTH    = TIME_WIDTH_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  s_tvalid,
	output logic                  s_tready,
	// step_done[1:0], ok[2], now_ms[34:3], zero fill
	input  logic [S_TDATA_W-1:0]  s_tdata,
	// func[0]
	input  logic                  s_tuser,
	output logic                  m_tvalid,
	input  logic                  m_tready,
	// next_step[1:0], degraded[2], failure_count[34:3], recovery_count[66:35],
	// bus_clear_count[98:67], hard_reset_count[130:99], streak_count[146:131],
	// last_recovery_time[178:147], zero fill
	output logic [M_TDATA_W-1:0]  m_tdata,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data
);

	cfg_t    cfg;
	item_t   item_s1;
	logic    valid_s1;
	result_t res;
	result_t res_s2;
	logic    valid_s2;
	logic    advance;
	logic    take;

	lrl_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	lrl_core #(
		.COUNTER_WIDTH (COUNTER_WIDTH),
		.TIME_WIDTH    (TIME_WIDTH)
	) u_core (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg),
		.item   (item_s1),
		.upd    (advance),
		.res    (res)
	);

	// Move the input stage forward when the result register is free or draining
	assign advance  = valid_s1 && (!valid_s2 || m_tready);
	assign s_tready = !valid_s1 || advance;
	assign take     = s_tvalid && s_tready;

	// Stage valid flags
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (take) begin
				valid_s1 <= 1'b1;
			end else if (advance) begin
				valid_s1 <= 1'b0;
			end
			if (advance) begin
				valid_s2 <= 1'b1;
			end else if (m_tready) begin
				valid_s2 <= 1'b0;
			end
		end
	end

	// Capture the input beat and the result
	always_ff @(posedge clk) begin
		if (take) begin
			item_s1.func      <= s_tuser;
			item_s1.step_done <= act_t'(s_tdata[1:0]);
			item_s1.ok        <= s_tdata[2];
			item_s1.now_ms    <= s_tdata[34:3];
		end
		if (advance) begin
			res_s2 <= res;
		end
	end

	assign m_tvalid = valid_s2;
	assign m_tdata  = {5'd0,
	                   res_s2.last_recovery_time,
	                   res_s2.streak_count,
	                   res_s2.hard_reset_count,
	                   res_s2.bus_clear_count,
	                   res_s2.recovery_count,
	                   res_s2.failure_count,
	                   res_s2.degraded,
	                   res_s2.next_step};

	// An accepted beat occupies the input stage next cycle
	a_take_fills: assert property (@(posedge clk) disable iff (!arst_n)
		take |=> valid_s1)
		else $error("accepted beat lost from input stage");

	// A waiting item moves into an empty result register
	a_flow: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && !valid_s2 |=> valid_s2)
		else $error("input stage did not advance into empty result stage");

	// Input side stays open whenever the result register can take the item
	a_open: assert property (@(posedge clk) disable iff (!arst_n)
		!valid_s2 |-> s_tready)
		else $error("input stalled with result register empty");

endmodule

[verif/link_recovery_ladder_tb.sv]
// Self-checking testbench for link_recovery_ladder: directed table, random
// plan/report traffic and a long failure streak, all checked against a predictor.
// Depends on lrl_pkg (hdl/lrl_pkg.sv) and the link_recovery_ladder RTL.
`timescale 1ns / 1ps

module link_recovery_ladder_tb;
	import lrl_pkg::*;

	localparam int CYCLE_LIMIT = 1_000_000;
	localparam int TAIL_CYCLES = 20;
	localparam int PRINT_CAP   = 40;
	localparam int N_ROWS      = 29;
	localparam int N_PHASES    = 8;
	localparam int PHASE_ITEMS = 116;

	localparam logic             FN_PLAN   = 1'b0;
	localparam logic             FN_REPORT = 1'b1;
	localparam logic [CFG_IDX_W-1:0] REG_SPARE = 2'd3;

	// One directed step: a register write (idx, val) or a beat (func, step, ok, val as now_ms)
	typedef struct packed {
		logic                  wr_cfg;
		logic [CFG_IDX_W-1:0]  idx;
		logic                  func;
		act_t                  step;
		logic                  ok;
		logic [31:0]           val;
		logic                  typed;
		act_t                  t_next;
		logic                  t_deg;
		logic [STREAK_W-1:0]   t_streak;
	} dir_row_t;

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  s_tvalid = 1'b0;
	logic                  s_tready;
	logic [S_TDATA_W-1:0]  s_tdata = '0;
	logic                  s_tuser = 1'b0;
	logic                  m_tvalid;
	logic                  m_tready = 1'b0;
	logic [M_TDATA_W-1:0]  m_tdata;
	logic                  cfg_we = 1'b0;
	logic [CFG_IDX_W-1:0]  cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_data = '0;

	int send_idle_pct  = 0;
	int recv_stall_pct = 0;
	int fault_cnt      = 0;
	int cycle_cnt      = 0;

	// Predicted link state and register copies, at their reset values
	mode_t               link_mode   = MODE_NORMAL;
	logic                ladder_hi   = 1'b0;
	logic [STREAK_W-1:0] fail_run    = '0;
	logic [31:0]         bo_len      = '0;
	logic [31:0]         bo_deadline = '0;
	logic [31:0]         n_fail      = '0;
	logic [31:0]         n_recov     = '0;
	logic [31:0]         n_busclr    = '0;
	logic [31:0]         n_hardrst   = '0;
	logic [31:0]         recov_stamp = '0;
	logic [STREAK_W-1:0] thr_cfg     = THRESHOLD_RESET;
	logic [31:0]         base_cfg    = BACKOFF_BASE_RST;
	logic [31:0]         cap_cfg     = BACKOFF_MAX_RST;

	result_t  health_due [$];
	dir_row_t dir_tbl [N_ROWS];

	link_recovery_ladder u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Abort a hung run
	always @(posedge clk) begin
		cycle_cnt <= cycle_cnt + 1;
		if (cycle_cnt == CYCLE_LIMIT) begin
			$display("status: fail");
			$finish;
		end
	end

	// Stall the result side at the current rate
	always @(posedge clk) begin
		m_tready <= ($urandom_range(99) >= recv_stall_pct);
	end

	task automatic flag_mismatch(input string what, input logic [63:0] got,
			input logic [63:0] want);
		if (fault_cnt < PRINT_CAP)
			$display("mismatch %s: got %0h want %0h at %0t", what, got, want, $realtime);
		fault_cnt++;
	endtask

	// Plan for the current state: ladder step in recover, wait until the deadline in backoff
	function automatic act_t next_action(input logic [31:0] now);
		logic [31:0] diff;
		diff = now - bo_deadline;
		if (link_mode == MODE_RECOVER)
			return ladder_hi ? ACT_HARDRESET : ACT_BUSCLEAR;
		if (link_mode == MODE_BACKOFF && diff[31])
			return ACT_WAIT;
		return ACT_ATTEMPT;
	endfunction

	task automatic note_recovery(input logic [31:0] now);
		n_recov++;
		recov_stamp = now;
		link_mode = MODE_NORMAL;
		ladder_hi = 1'b0;
		fail_run = '0;
		bo_len = '0;
	endtask

	// Apply one beat to the predicted state and form its health result
	task automatic predict_health(input item_t it, output result_t r);
		logic [32:0] wide;
		if (it.func == FN_REPORT) begin
			case (it.step_done)
			ACT_ATTEMPT: begin
				if (it.ok) begin
					if (link_mode != MODE_NORMAL)
						note_recovery(it.now_ms);
					else
						fail_run = '0;
				end else begin
					n_fail++;
					if (fail_run != STREAK_MAX)
						fail_run++;
					if (link_mode == MODE_BACKOFF ||
							(link_mode == MODE_NORMAL && fail_run >= thr_cfg)) begin
						link_mode = MODE_RECOVER;
						ladder_hi = 1'b0;
					end
				end
			end
			ACT_BUSCLEAR: begin
				n_busclr++;
				if (it.ok)
					note_recovery(it.now_ms);
				else
					ladder_hi = 1'b1;
			end
			ACT_HARDRESET: begin
				n_hardrst++;
				if (it.ok) begin
					note_recovery(it.now_ms);
				end else begin
					// Double wide so the product cannot wrap, then cap
					if (bo_len == '0) begin
						bo_len = base_cfg;
					end else if (bo_len < cap_cfg) begin
						wide = {bo_len, 1'b0};
						bo_len = (wide > {1'b0, cap_cfg}) ? cap_cfg : wide[31:0];
					end
					bo_deadline = it.now_ms + bo_len;
					link_mode = MODE_BACKOFF;
					ladder_hi = 1'b0;
				end
			end
			default: ;
			endcase
		end
		r.next_step          = next_action(it.now_ms);
		r.degraded           = (link_mode != MODE_NORMAL);
		r.failure_count      = n_fail;
		r.recovery_count     = n_recov;
		r.bus_clear_count    = n_busclr;
		r.hard_reset_count   = n_hardrst;
		r.streak_count       = fail_run;
		r.last_recovery_time = recov_stamp;
	endtask

	// Offer one beat after a random idle gap; record its expected result once taken
	task automatic send_item(input item_t it);
		result_t r;
		while ($urandom_range(99) < send_idle_pct) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser  <= it.func;
		s_tdata  <= S_TDATA_W'({it.now_ms, it.ok, it.step_done});
		do @(posedge clk); while (!s_tready);
		predict_health(it, r);
		health_due.push_back(r);
	endtask

	// Hold the input side until every expected result has drained
	task automatic settle();
		s_tvalid <= 1'b0;
		while (health_due.size() != 0)
			@(posedge clk);
	endtask

	// Raise the write strobe and update the register copy; the caller drops it after the last write
	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] val);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		@(posedge clk);
		case (idx)
		REG_FAIL_THRESHOLD: thr_cfg  = val[STREAK_W-1:0];
		REG_BACKOFF_BASE:   base_cfg = val;
		REG_BACKOFF_MAX:    cap_cfg  = val;
		default: ;
		endcase
	endtask

	// Check each result beat against the oldest expectation
	always @(posedge clk) begin
		result_t want;
		if (arst_n && m_tvalid && m_tready) begin
			if (health_due.size() == 0) begin
				flag_mismatch("unexpected beat", m_tdata[63:0], '0);
			end else begin
				want = health_due.pop_front();
				if (m_tdata[1:0] !== want.next_step)
					flag_mismatch("next_step", 64'(m_tdata[1:0]), 64'(want.next_step));
				if (m_tdata[2] !== want.degraded)
					flag_mismatch("degraded", 64'(m_tdata[2]), 64'(want.degraded));
				if (m_tdata[34:3] !== want.failure_count)
					flag_mismatch("failure_count", 64'(m_tdata[34:3]),
						64'(want.failure_count));
				if (m_tdata[66:35] !== want.recovery_count)
					flag_mismatch("recovery_count", 64'(m_tdata[66:35]),
						64'(want.recovery_count));
				if (m_tdata[98:67] !== want.bus_clear_count)
					flag_mismatch("bus_clear_count", 64'(m_tdata[98:67]),
						64'(want.bus_clear_count));
				if (m_tdata[130:99] !== want.hard_reset_count)
					flag_mismatch("hard_reset_count", 64'(m_tdata[130:99]),
						64'(want.hard_reset_count));
				if (m_tdata[146:131] !== want.streak_count)
					flag_mismatch("streak_count", 64'(m_tdata[146:131]),
						64'(want.streak_count));
				if (m_tdata[178:147] !== want.last_recovery_time)
					flag_mismatch("last_recovery_time", 64'(m_tdata[178:147]),
						64'(want.last_recovery_time));
			end
		end
	end

	initial begin
		item_t       it;
		result_t     r;
		dir_row_t    row;
		logic [31:0] clock_ms;
		int          pick;
		int          last;

		// Walk the ladder by hand: plan answers, backoff wait edge, recoveries,
		// zero threshold, wrapped deadline, capped doubling, spare register index
		dir_tbl = '{
			'{1'b0, REG_SPARE, FN_PLAN, ACT_ATTEMPT, 1'b0, 32'h0,
				1'b1, ACT_ATTEMPT, 1'b0, 16'd0},
			'{1'b0, REG_SPARE, FN_PLAN, ACT_WAIT, 1'b1, 32'hFFFF_FFFF,
				1'b1, ACT_ATTEMPT, 1'b0, 16'd0},
			'{1'b0, REG_SPARE, FN_REPORT, ACT_ATTEMPT, 1'b0, 32'd10,
				1'b1, ACT_ATTEMPT, 1'b0, 16'd1},
			'{1'b0, REG_SPARE, FN_REPORT, ACT_WAIT, 1'b1, 32'd20,
				1'b1, ACT_ATTEMPT, 1'b0, 16'd1},
			'{1'b0, REG_SPARE, FN_REPORT, ACT_ATTEMPT, 1'b0, 32'd30,
				1'b0, ACT_ATTEMPT, 1'b0, 16'd0},
			'{1'b0, REG_SPARE, FN_REPORT, ACT_ATTEMPT, 1'b0, 32'd40,
				1'b1, ACT_BUSCLEAR, 1'b1, 16'd3},
			'{1'b0, REG_SPARE, FN_PLAN, ACT_ATTEMPT, 1'b0, 32'd50,
				1'b1, ACT_BUSCLEAR, 1'b1, 16'd3},
			'{1'b0, REG_SPARE, FN_REPORT, ACT_BUSCLEAR, 1'b0, 32'd60,
				1'b1, ACT_HARDRESET, 1'b1, 16'd3},
			'{1'b0, REG_SPARE, FN_REPORT, ACT_HARDRESET, 1'b0, 32'd100,
				1'b1, ACT_WAIT, 1'b1, 16'd3},
			'{1'b0, REG_SPARE, FN_PLAN, ACT_ATTEMPT, 1'b0, 32'd1099,
				1'b1, ACT_WAIT, 1'b1, 16'd3},
			'{1'b0, REG_SPARE, FN_PLAN, ACT_ATTEMPT, 1'b0, 32'd1100,
				1'b1, ACT_ATTEMPT, 1'b1, 16'd3},
			'{1'b0, REG_SPARE, FN_REPORT, ACT_ATTEMPT, 1'b0, 32'd1200,
				1'b1, ACT_BUSCLEAR, 1'b1, 16'd4},
			'{1'b0, REG_SPARE, FN_REPORT, ACT_BUSCLEAR, 1'b0, 32'd1300,
				1'b0, ACT_ATTEMPT, 1'b0, 16'd0},
			'{1'b0, REG_SPARE, FN_REPORT, ACT_HARDRESET, 1'b0, 32'd2000,
				1'b1, ACT_WAIT, 1'b1, 16'd4},
			'{1'b0, REG_SPARE, FN_REPORT, ACT_ATTEMPT, 1'b1, 32'd5000,
				1'b1, ACT_ATTEMPT, 1'b0, 16'd0},
			'{1'b0, REG_SPARE, FN_REPORT, ACT_BUSCLEAR, 1'b1, 32'd6000,
				1'b1, ACT_ATTEMPT, 1'b0, 16'd0},
			'{1'b0, REG_SPARE, FN_REPORT, ACT_HARDRESET, 1'b1, 32'hFFFF_FFFF,
				1'b1, ACT_ATTEMPT, 1'b0, 16'd0},
			'{1'b0, REG_SPARE, FN_REPORT, ACT_ATTEMPT, 1'b1, 32'd7,
				1'b1, ACT_ATTEMPT, 1'b0, 16'd0},
			'{1'b0, REG_SPARE, FN_REPORT, ACT_WAIT, 1'b0, 32'd8,
				1'b0, ACT_ATTEMPT, 1'b0, 16'd0},
			'{1'b1, REG_FAIL_THRESHOLD, FN_PLAN, ACT_ATTEMPT, 1'b0, 32'd0,
				1'b0, ACT_ATTEMPT, 1'b0, 16'd0},
			'{1'b0, REG_SPARE, FN_REPORT, ACT_ATTEMPT, 1'b0, 32'd9,
				1'b1, ACT_BUSCLEAR, 1'b1, 16'd1},
			'{1'b1, REG_BACKOFF_BASE, FN_PLAN, ACT_ATTEMPT, 1'b0, 32'hFFFF_FFF0,
				1'b0, ACT_ATTEMPT, 1'b0, 16'd0},
			'{1'b1, REG_BACKOFF_MAX, FN_PLAN, ACT_ATTEMPT, 1'b0, 32'hFFFF_FFFF,
				1'b0, ACT_ATTEMPT, 1'b0, 16'd0},
			'{1'b0, REG_SPARE, FN_REPORT, ACT_BUSCLEAR, 1'b0, 32'd10,
				1'b1, ACT_HARDRESET, 1'b1, 16'd1},
			'{1'b0, REG_SPARE, FN_REPORT, ACT_HARDRESET, 1'b0, 32'h20,
				1'b1, ACT_ATTEMPT, 1'b1, 16'd1},
			'{1'b0, REG_SPARE, FN_REPORT, ACT_ATTEMPT, 1'b0, 32'h30,
				1'b1, ACT_BUSCLEAR, 1'b1, 16'd2},
			'{1'b0, REG_SPARE, FN_REPORT, ACT_BUSCLEAR, 1'b0, 32'h40,
				1'b0, ACT_ATTEMPT, 1'b0, 16'd0},
			'{1'b0, REG_SPARE, FN_REPORT, ACT_HARDRESET, 1'b0, 32'h50,
				1'b1, ACT_ATTEMPT, 1'b1, 16'd2},
			'{1'b1, REG_SPARE, FN_PLAN, ACT_ATTEMPT, 1'b0, 32'hFFFF_FFFF,
				1'b0, ACT_ATTEMPT, 1'b0, 16'd0}
		};

		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed part; register writes wait for the pipe to drain
		for (int i = 0; i < N_ROWS; i++) begin
			row = dir_tbl[i];
			if (row.wr_cfg) begin
				if (i == 0 || !dir_tbl[i-1].wr_cfg)
					settle();
				write_reg(row.idx, row.val);
				if (i + 1 == N_ROWS || !dir_tbl[i+1].wr_cfg)
					cfg_we <= 1'b0;
			end else begin
				it.func      = row.func;
				it.step_done = row.step;
				it.ok        = row.ok;
				it.now_ms    = row.val;
				send_item(it);
				// Pin the fields that are plain to see on this row
				if (row.typed) begin
					last = health_due.size() - 1;
					r = health_due[last];
					r.next_step    = row.t_next;
					r.degraded     = row.t_deg;
					r.streak_count = row.t_streak;
					health_due[last] = r;
				end
			end
		end

		// Random part: mostly follow the plan, with some noise and broken ladders
		clock_ms = $urandom;
		for (int ph = 0; ph < N_PHASES; ph++) begin
			settle();
			case (ph)
			0: begin
				write_reg(REG_FAIL_THRESHOLD, 32'd3);
				write_reg(REG_BACKOFF_BASE, 32'd1000);
				write_reg(REG_BACKOFF_MAX, 32'd60000);
			end
			1: begin
				write_reg(REG_FAIL_THRESHOLD, 32'd0);
				write_reg(REG_BACKOFF_BASE, 32'd0);
				write_reg(REG_BACKOFF_MAX, 32'd0);
			end
			2: begin
				write_reg(REG_FAIL_THRESHOLD, 32'd1);
				write_reg(REG_BACKOFF_BASE, 32'h8000_0001);
				write_reg(REG_BACKOFF_MAX, 32'hFFFF_FFFF);
			end
			3: begin
				write_reg(REG_FAIL_THRESHOLD, 32'd2);
				write_reg(REG_BACKOFF_BASE, 32'd5);
				write_reg(REG_BACKOFF_MAX, 32'd7);
				write_reg(REG_SPARE, $urandom);
			end
			4: begin
				write_reg(REG_FAIL_THRESHOLD, 32'd2);
				write_reg(REG_BACKOFF_BASE, 32'd500);
				write_reg(REG_BACKOFF_MAX, 32'd400);
			end
			5: begin
				write_reg(REG_FAIL_THRESHOLD, $urandom_range(6));
				write_reg(REG_BACKOFF_BASE, $urandom);
				write_reg(REG_BACKOFF_MAX, $urandom);
			end
			6: begin
				write_reg(REG_FAIL_THRESHOLD, 32'd4);
				write_reg(REG_BACKOFF_BASE, 32'd1);
				write_reg(REG_BACKOFF_MAX, 32'h0010_0000);
			end
			default: begin
				write_reg(REG_FAIL_THRESHOLD, $urandom_range(3));
				write_reg(REG_BACKOFF_BASE, $urandom_range(3000));
				write_reg(REG_BACKOFF_MAX, $urandom_range(100000));
			end
			endcase
			cfg_we <= 1'b0;

			// Idle profile: none, sender idle, receiver stalling, both light
			case (ph % 4)
			0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
			1: begin send_idle_pct = 86; recv_stall_pct = 0;  end
			2: begin send_idle_pct = 0;  recv_stall_pct = 86; end
			default: begin send_idle_pct = 8; recv_stall_pct = 8; end
			endcase

			repeat (PHASE_ITEMS) begin
				pick = $urandom_range(99);
				if (pick < 15) begin
					it.func      = 1'($urandom_range(1));
					it.step_done = act_t'($urandom_range(3));
					it.ok        = 1'($urandom_range(1));
					it.now_ms    = $urandom;
				end else begin
					it.now_ms = clock_ms;
					it.ok     = ($urandom_range(99) < 35);
					if (pick < 35) begin
						it.func      = FN_PLAN;
						it.step_done = act_t'($urandom_range(3));
					end else begin
						it.func      = FN_REPORT;
						it.step_done = next_action(clock_ms);
					end
				end
				send_item(it);
				// Advance time: small steps, some long gaps, rare arbitrary jumps
				pick = $urandom_range(99);
				if (pick < 70)
					clock_ms += $urandom_range(400);
				else if (pick < 95)
					clock_ms += $urandom_range(70000);
				else
					clock_ms += $urandom;
			end
		end

		// Run a failure streak under the widest threshold, back to back
		settle();
		write_reg(REG_FAIL_THRESHOLD, 32'hFFFF);
		cfg_we <= 1'b0;
		send_idle_pct  = 0;
		recv_stall_pct = 0;
		it.func      = FN_REPORT;
		it.step_done = ACT_ATTEMPT;
		it.ok        = 1'b1;
		it.now_ms    = clock_ms;
		send_item(it);
		it.ok = 1'b0;
		repeat (12) begin
			it.now_ms = clock_ms;
			send_item(it);
			clock_ms += $urandom_range(3);
		end

		settle();
		repeat (TAIL_CYCLES) @(posedge clk);
		if (health_due.size() != 0)
			flag_mismatch("results missing", 64'(health_due.size()), '0);
		if (fault_cnt == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

endmodule
